>>> sv/fmx_pkg.sv
// fmx_pkg: shared types and constants for the queue with minimum extraction
// used by fmx_store, fmx_scan and fifo_with_min_extract_unit; no dependencies
`timescale 1ns / 1ps

package fmx_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int OCC_W     = 5;

	localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;
	localparam logic [DATA_W-1:0] PUSH_VALUE  = '0;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_MINPOP = 2'd2,
		CMD_PEEK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// control from the sequencer to the shared comparator
	typedef struct packed {
		logic en;
		logic first;
	} scan_ctl_t;

endpackage

>>> sv/fmx_store.sv
// fmx_store: entry memory, one write port and one read port with registered data
// depends on fmx_pkg for the default depth and data width
`timescale 1ns / 1ps

module fmx_store #(
	parameter int DEPTH = fmx_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [AW-1:0]                  waddr,
	input  logic [fmx_pkg::DATA_W-1:0]     wdata,
	input  logic                           re,
	input  logic [AW-1:0]                  raddr,
	output logic [fmx_pkg::DATA_W-1:0]     rdata
);

	logic [fmx_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [fmx_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/fmx_scan.sv
// fmx_scan: shared signed comparator that tracks the smallest entry seen and its slot
// depends on fmx_pkg for scan_ctl_t and the data width
`timescale 1ns / 1ps

module fmx_scan #(
	parameter int DEPTH = fmx_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  fmx_pkg::scan_ctl_t                ctl,
	input  logic signed [fmx_pkg::DATA_W-1:0] data,
	input  logic [AW-1:0]                     idx,
	output logic signed [fmx_pkg::DATA_W-1:0] best_val,
	output logic [AW-1:0]                     best_idx
);

	logic signed [fmx_pkg::DATA_W-1:0] best_val_q;
	logic [AW-1:0]                     best_idx_q;
	logic                              take;

	// strict less keeps the earliest slot on ties
	assign take = ctl.first || (data < best_val_q);

	always_ff @(posedge clk) begin
		if (ctl.en && take) begin
			best_val_q <= data;
			best_idx_q <= idx;
		end
	end

	assign best_val = best_val_q;
	assign best_idx = best_idx_q;

endmodule

>>> sv/fifo_with_min_extract_unit.sv
// fifo_with_min_extract_unit: top level, command sequencer, occupancy and result registers
// depends on fmx_pkg, fmx_store and fmx_scan
`timescale 1ns / 1ps

// Bounded queue of signed 32-bit values in arrival order. A command is taken when start is
// high and busy is low; its single result appears on result_value, status and occupancy for
// exactly one cycle with done high, and must be captured then. Push, and any command on an
// empty queue, finishes straight from idle. Peek and pop read only the oldest entry,
// and min-pop scans the held entries one per cycle through a single comparator. Pop and min-pop
// then close the gap one entry per cycle through the memory's single write port. The next command
// can be given in the cycle done is high.

module fifo_with_min_extract_unit #(
	parameter int DEPTH = fmx_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        cmd,
	input  logic signed [fmx_pkg::DATA_W-1:0] value,
	output logic                              done,
	output logic signed [fmx_pkg::DATA_W-1:0] result_value,
	output logic [1:0]                        status,
	output logic [fmx_pkg::OCC_W-1:0]         occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE      = CW'(1);
	localparam logic [CW-1:0] TWO      = CW'(2);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_PICK  = 4'b0100,
		S_SHIFT = 4'b1000
	} state_t;

	state_t                       state_q;
	fmx_pkg::cmd_t                cmd_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                ptr_q;
	logic [CW-1:0]                idx_q;
	logic [CW-1:0]                lim_q;
	logic                         done_q;
	logic [fmx_pkg::DATA_W-1:0]   res_q;
	logic [1:0]                   status_q;
	logic [fmx_pkg::OCC_W-1:0]    occ_q;

	logic                         we;
	logic [AW-1:0]                waddr;
	logic [fmx_pkg::DATA_W-1:0]   wdata;
	logic                         re;
	logic [AW-1:0]                raddr;
	logic [fmx_pkg::DATA_W-1:0]   rdata;

	fmx_pkg::scan_ctl_t           scan_ctl;
	logic signed [fmx_pkg::DATA_W-1:0] best_val;
	logic [AW-1:0]                best_idx;
	logic [CW-1:0]                pick_next;

	logic                         fin;
	logic [fmx_pkg::DATA_W-1:0]   res_nx;
	fmx_pkg::status_t             st_nx;
	logic [CW-1:0]                cnt_nx;
	logic                         accept;
	logic                         is_full;

	assign accept    = start && (state_q == S_IDLE);
	assign is_full   = (cnt_q >= FULL_CNT);
	assign pick_next = CW'(best_idx) + ONE;

	fmx_store #(.DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	fmx_scan #(.DEPTH(DEPTH)) u_scan (
		.clk      (clk),
		.ctl      (scan_ctl),
		.data     (rdata),
		.idx      (idx_q[AW-1:0]),
		.best_val (best_val),
		.best_idx (best_idx)
	);

	// memory port, comparator and result selection
	always_comb begin
		we       = 1'b0;
		waddr    = cnt_q[AW-1:0];
		wdata    = value;
		re       = 1'b0;
		raddr    = '0;
		scan_ctl = '0;
		fin      = 1'b0;
		res_nx   = best_val;
		st_nx    = fmx_pkg::ST_OK;
		cnt_nx   = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd == fmx_pkg::CMD_PUSH) begin
						fin    = 1'b1;
						res_nx = fmx_pkg::PUSH_VALUE;
						if (is_full) begin
							st_nx = fmx_pkg::ST_FULL;
						end else begin
							we     = 1'b1;
							cnt_nx = cnt_q + ONE;
						end
					end else if (cnt_q == '0) begin
						fin    = 1'b1;
						res_nx = fmx_pkg::EMPTY_VALUE;
						st_nx  = fmx_pkg::ST_EMPTY;
					end else begin
						re = 1'b1;
					end
				end
			end
			S_SCAN: begin
				scan_ctl.en    = 1'b1;
				scan_ctl.first = (idx_q == '0);
				re             = (ptr_q < lim_q);
				raddr          = ptr_q[AW-1:0];
			end
			S_PICK: begin
				if (cmd_q == fmx_pkg::CMD_PEEK) begin
					fin = 1'b1;
				end else if (pick_next == cnt_q) begin
					fin    = 1'b1;
					cnt_nx = cnt_q - ONE;
				end else begin
					re    = 1'b1;
					raddr = pick_next[AW-1:0];
				end
			end
			S_SHIFT: begin
				// move the later entries down by one slot
				we    = 1'b1;
				waddr = idx_q[AW-1:0];
				wdata = rdata;
				re    = (ptr_q < cnt_q);
				raddr = ptr_q[AW-1:0];
				if (CW'(idx_q + TWO) == cnt_q) begin
					fin    = 1'b1;
					cnt_nx = cnt_q - ONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= fmx_pkg::CMD_PUSH;
			cnt_q   <= '0;
			ptr_q   <= '0;
			idx_q   <= '0;
			lim_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin;
			cnt_q  <= cnt_nx;
			unique case (state_q)
				S_IDLE: begin
					if (accept && !fin) begin
						cmd_q   <= fmx_pkg::cmd_t'(cmd);
						ptr_q   <= ONE;
						idx_q   <= '0;
						lim_q   <= (cmd == fmx_pkg::CMD_MINPOP) ? cnt_q : ONE;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					ptr_q <= ptr_q + ONE;
					idx_q <= idx_q + ONE;
					if (idx_q == lim_q - ONE) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					if (fin) begin
						state_q <= S_IDLE;
					end else begin
						idx_q   <= CW'(best_idx);
						ptr_q   <= pick_next + ONE;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					ptr_q <= ptr_q + ONE;
					idx_q <= idx_q + ONE;
					if (fin) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_q    <= res_nx;
			status_q <= st_nx;
			occ_q    <= fmx_pkg::OCC_W'(cnt_nx);
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign result_value = res_q;
	assign status       = status_q;
	assign occupancy    = occ_q;

	// a refused push is only reported with the queue full
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == fmx_pkg::ST_FULL) |-> (occupancy == fmx_pkg::OCC_W'(DEPTH)))
		else $error("full status with queue not full");

	// an empty result carries the empty marker and no entries
	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == fmx_pkg::ST_EMPTY) |->
		(result_value == fmx_pkg::EMPTY_VALUE && occupancy == '0))
		else $error("empty status with wrong value or occupancy");

	// a push transaction always finishes in the following cycle
	a_push_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == fmx_pkg::CMD_PUSH) |=> done)
		else $error("push did not finish in one cycle");

	// a result only appears once the sequencer is idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("entry count beyond capacity");

endmodule

>>> tb/sv/tb_fifo_with_min_extract_unit.sv
// tb_fifo_with_min_extract_unit: self-checking bench for the queue with minimum extraction
// directed table then biased random commands, results checked by a predictor or typed row
// depends on fmx_pkg and fifo_with_min_extract_unit
`timescale 1ns / 1ps

module tb_fifo_with_min_extract_unit;

	localparam int DATA_W      = fmx_pkg::DATA_W;
	localparam int OCC_W       = fmx_pkg::OCC_W;
	localparam int CAPACITY    = fmx_pkg::DEPTH_DEF;
	localparam int RANDOM_CMDS = 2000;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 2 * CAPACITY + 8;
	localparam int PLAN_ROWS   = 20;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		fmx_pkg::status_t         status;
		logic [OCC_W-1:0]         occupancy;
	} queue_result_t;

	typedef struct packed {
		fmx_pkg::cmd_t            op;
		logic signed [DATA_W-1:0] operand;
		int                       reps;
		logic                     known;
		queue_result_t            want;
	} plan_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               cmd;
	logic signed [DATA_W-1:0] value;
	logic                     done;
	logic signed [DATA_W-1:0] result_value;
	logic [1:0]               status;
	logic [OCC_W-1:0]         occupancy;

	// typed-in expectation travelling with the transaction on the command ports
	logic          fixed_on;
	queue_result_t fixed_want;

	logic signed [DATA_W-1:0] held[$];
	queue_result_t            pending_results[$];
	int                       mismatch_count;
	int                       fail_count;
	int                       cycle_count;

	fifo_with_min_extract_unit #(.DEPTH(CAPACITY)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.value(value),
		.done(done),
		.result_value(result_value),
		.status(status),
		.occupancy(occupancy)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic queue_result_t apply_command(fmx_pkg::cmd_t op,
			logic signed [DATA_W-1:0] operand);
		queue_result_t r;
		int best;
		r.value  = fmx_pkg::PUSH_VALUE;
		r.status = fmx_pkg::ST_OK;
		if (op == fmx_pkg::CMD_PUSH) begin
			if (held.size() >= CAPACITY)
				r.status = fmx_pkg::ST_FULL;
			else
				held.push_back(operand);
		end else if (held.size() == 0) begin
			r.value  = fmx_pkg::EMPTY_VALUE;
			r.status = fmx_pkg::ST_EMPTY;
		end else begin
			unique case (op)
				fmx_pkg::CMD_POP: begin
					r.value = held.pop_front();
				end
				fmx_pkg::CMD_MINPOP: begin
					// strict less keeps the earliest of equal minima
					best = 0;
					for (int i = 1; i < held.size(); i++)
						if (held[i] < held[best])
							best = i;
					r.value = held[best];
					held.delete(best);
				end
				default: begin
					r.value = held[0];
				end
			endcase
		end
		r.occupancy = OCC_W'(held.size());
		return r;
	endfunction

	function automatic int pick_gap(bit quiet);
		int k;
		k = $urandom_range(0, 99);
		if (quiet || k < 60)
			return 0;
		if (k < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5)
			return $urandom;
		if (k < 8)
			return $signed($urandom_range(0, 6)) - 3;
		if (k == 8)
			return 32'sh8000_0000 + $urandom_range(0, 2);
		return 32'sh7fff_ffff - $urandom_range(0, 2);
	endfunction

	// present one transaction from the falling edge until busy is low at a rising edge
	task automatic issue(fmx_pkg::cmd_t op, logic signed [DATA_W-1:0] operand, logic known,
			queue_result_t want, int gap);
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start      = 1'b1;
		cmd        = op;
		value      = operand;
		fixed_on   = known;
		fixed_want = want;
		do @(posedge clk); while (busy);
	endtask

	// prediction on acceptance, then comparison of any result in the same edge
	always @(posedge clk) begin
		queue_result_t predicted;
		queue_result_t want;
		if (arst_n) begin
			if (start && !busy) begin
				predicted = apply_command(fmx_pkg::cmd_t'(cmd), value);
				pending_results.push_back(fixed_on ? fixed_want : predicted);
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: value %0d status %0d occupancy %0d",
							result_value, status, occupancy);
				end else begin
					want = pending_results.pop_front();
					if (result_value !== want.value || status !== want.status
							|| occupancy !== want.occupancy) begin
						fail_count++;
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch exp/act: value %0d/%0d status %0d/%0d occ %0d/%0d",
								want.value, result_value, want.status, status,
								want.occupancy, occupancy);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		plan_row_t plan [PLAN_ROWS];
		queue_result_t none;
		int push_pct;
		bit quiet;
		fmx_pkg::cmd_t op;

		arst_n         = 1'b0;
		start          = 1'b0;
		cmd            = fmx_pkg::CMD_PUSH;
		value          = '0;
		fixed_on       = 1'b0;
		fixed_want     = '0;
		mismatch_count = 0;
		fail_count     = 0;
		none           = '{fmx_pkg::PUSH_VALUE, fmx_pkg::ST_OK, '0};

		plan = '{
			// empty queue on every reading command
			'{fmx_pkg::CMD_POP, 32'sh0, 1, 1'b1,
				'{fmx_pkg::EMPTY_VALUE, fmx_pkg::ST_EMPTY, 5'd0}},
			'{fmx_pkg::CMD_MINPOP, 32'sh0, 1, 1'b1,
				'{fmx_pkg::EMPTY_VALUE, fmx_pkg::ST_EMPTY, 5'd0}},
			'{fmx_pkg::CMD_PEEK, 32'sh7fff_ffff, 1, 1'b1,
				'{fmx_pkg::EMPTY_VALUE, fmx_pkg::ST_EMPTY, 5'd0}},
			// extremes of the value range
			'{fmx_pkg::CMD_PUSH, 32'sh8000_0000, 1, 1'b1,
				'{fmx_pkg::PUSH_VALUE, fmx_pkg::ST_OK, 5'd1}},
			'{fmx_pkg::CMD_PUSH, 32'sh7fff_ffff, 1, 1'b1,
				'{fmx_pkg::PUSH_VALUE, fmx_pkg::ST_OK, 5'd2}},
			'{fmx_pkg::CMD_PUSH, -32'sd1, 1, 1'b1,
				'{fmx_pkg::PUSH_VALUE, fmx_pkg::ST_OK, 5'd3}},
			'{fmx_pkg::CMD_PUSH, 32'sh0, 1, 1'b1,
				'{fmx_pkg::PUSH_VALUE, fmx_pkg::ST_OK, 5'd4}},
			'{fmx_pkg::CMD_PEEK, 32'sh0, 1, 1'b1,
				'{32'sh8000_0000, fmx_pkg::ST_OK, 5'd4}},
			'{fmx_pkg::CMD_MINPOP, 32'sh0, 1, 1'b1,
				'{32'sh8000_0000, fmx_pkg::ST_OK, 5'd3}},
			// equal minima: the earlier one must go first
			'{fmx_pkg::CMD_PUSH,   32'sh0,         1, 1'b0, none},
			'{fmx_pkg::CMD_PUSH,   -32'sd1,        1, 1'b0, none},
			'{fmx_pkg::CMD_MINPOP, 32'sh0,         1, 1'b0, none},
			'{fmx_pkg::CMD_MINPOP, 32'sh0,         1, 1'b0, none},
			'{fmx_pkg::CMD_POP,    32'sh0,         1, 1'b0, none},
			// fill to capacity, then a refused push
			'{fmx_pkg::CMD_PUSH,   32'sh5555_5555, 7, 1'b0, none},
			'{fmx_pkg::CMD_PUSH,   32'shaaaa_aaaa, 7, 1'b0, none},
			'{fmx_pkg::CMD_PUSH, 32'sh1234_5678, 1, 1'b1,
				'{fmx_pkg::PUSH_VALUE, fmx_pkg::ST_FULL, 5'd16}},
			'{fmx_pkg::CMD_MINPOP, 32'sh0,         1, 1'b0, none},
			'{fmx_pkg::CMD_PEEK,   32'sh0,         1, 1'b0, none},
			'{fmx_pkg::CMD_POP,    32'sh0,         1, 1'b0, none}
		};

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan[r])
			repeat (plan[r].reps)
				issue(plan[r].op, plan[r].operand, plan[r].known, plan[r].want, pick_gap(1'b0));

		push_pct = 50;
		quiet    = 1'b0;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			// swing between filling, draining and balanced traffic
			if (n % 64 == 0)
				case ($urandom_range(0, 2))
					0:       push_pct = 75;
					1:       push_pct = 20;
					default: push_pct = 48;
				endcase
			if (n % 250 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < push_pct)
				op = fmx_pkg::CMD_PUSH;
			else
				op = fmx_pkg::cmd_t'($urandom_range(1, 3));
			issue(op, pick_value(), 1'b0, none, pick_gap(quiet));
		end

		@(negedge clk);
		start = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_results.size() != 0)
			fail_count++;

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
